// File: hdl/stap_pkg.sv
// shared types, constants and sine table generator for the tremolo / auto-pan unit
package stap_pkg;

  // fixed point constants
  localparam int unsigned GAIN_ONE   = 32768;
  localparam int unsigned GAIN_HALF  = 16384;
  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // widths fixed by the register map
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned STEP_W  = 22;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_W   = 22;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned MUL_BW  = 18;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_DEPTH_GAIN  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_EFFECT_MODE = 2'd2;

  // effect modes
  localparam logic [MODE_W-1:0] MODE_VOLUME  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TREMOLO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AUTOPAN = 2'd2;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL_A = 6'b000010,
    ST_MUL_C = 6'b000100,
    ST_MUL_L = 6'b001000,
    ST_MUL_R = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // sin(pi/2 * k / 2^depth_log2) in Q15, odd series to x^11 in Q30
  function automatic logic [15:0] sine_entry(input int unsigned k,
                                             input int unsigned depth_log2);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(k) * HALF_PI_Q30) >> depth_log2;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (((x * t) >> 30) + (64'd1 << 14)) >> 15;
    if (s > 64'(GAIN_ONE)) begin
      s = 64'(GAIN_ONE);
    end
    return s[15:0];
  endfunction

endpackage

// File: hdl/stap_in_if.sv
// input channel carrying one stereo sample pair per transfer
interface stap_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// File: hdl/stap_out_if.sv
// output channel carrying one modulated stereo sample pair per transfer
interface stap_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// File: hdl/stap_sine_rom.sv
// quarter-wave sine table with registered read
module stap_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [$clog2(SINE_TABLE_DEPTH):0]   addr,
  output logic [15:0]                         data
);
  localparam int DEPTH_LOG2 = $clog2(SINE_TABLE_DEPTH);

  logic [15:0] rom_tab [SINE_TABLE_DEPTH+1];

  // table entries folded to constants at elaboration
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    assign rom_tab[k] = stap_pkg::sine_entry(k, DEPTH_LOG2);
  end

  // registered read
  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom_tab[addr];
    end
  end
endmodule

// File: hdl/stap_mult.sv
// shared signed multiplier with registered product
module stap_mult #(
  parameter int AW = 17,
  parameter int BW = 18
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] op_a,
  input  logic signed [BW-1:0] op_b,
  output logic signed [AW+BW-1:0] prod
);
  // one product per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a * op_b;
    end
  end
endmodule

// File: hdl/stereo_tremolo_autopan_unit.sv
// top level of the lfo tremolo / auto-pan unit: registers, sequencer, datapath
// Each accepted stereo pair is scaled by a gain set by effect_mode: plain volume
// (depth_gain), tremolo (both channels follow the lfo) or auto-pan (channels
// follow the lfo in opposite directions). Each pair keeps the unit busy through
// the accept cycle, in which the sine table is read, four passes through the
// single shared multiplier (two for the lfo gains, one per channel) and the
// load of the output register. The input is ready again in the cycle after the
// result is loaded, so a new pair can be taken while that result waits for its
// output transfer; a pair that reaches the load step while the previous result
// still waits is held there until the output transfer. Input ready is low during
// reset. The lfo phase advances by phase_step on every input transfer.
// Configuration writes take effect at once and are meant for idle periods;
// depth_gain above 1.0 counts as 1.0 and effect_mode 3 acts as volume.
module stereo_tremolo_autopan_unit #(
  parameter int PHASE_BITS       = 32,
  parameter int SAMPLE_BITS      = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  stap_in_if.sink                           in_ch,
  stap_out_if.source                        out_ch,
  input  logic                              cfg_write,
  input  logic [stap_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [stap_pkg::CFG_W-1:0]        cfg_data
);
  localparam int DL = $clog2(SINE_TABLE_DEPTH);
  localparam int AW = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
  localparam int BW = stap_pkg::MUL_BW;
  localparam int PW = AW + BW;
  localparam int GW = stap_pkg::GAIN_W;
  localparam int SW = stap_pkg::STEP_W;

  // configuration registers
  logic [GW-1:0]                     depth_gain;
  logic [stap_pkg::STEP_W-1:0]       phase_step;
  logic [stap_pkg::MODE_W-1:0]       effect_mode;

  // state and working registers
  logic [PHASE_BITS-1:0]             lfo_phase;
  stap_pkg::state_t                  state;
  stap_pkg::state_t                  state_next;
  logic                              quad_neg;
  logic signed [SAMPLE_BITS-1:0]     xl;
  logic signed [SAMPLE_BITS-1:0]     xr;
  logic [GW-1:0]                     gain_b;
  logic [GW-1:0]                     gain_c;
  logic signed [SAMPLE_BITS-1:0]     res_l;
  logic                              out_valid;

  // datapath wires
  logic                              in_xfer;
  logic                              out_load;
  logic [1:0]                        quad;
  logic [DL-1:0]                     kidx;
  logic [DL:0]                       rom_addr;
  logic [15:0]                       rom_q;
  logic [GW-1:0]                     d_sat;
  logic [GW-1:0]                     gain_base;
  logic [GW-1:0]                     lfo_a;
  logic [GW-1:0]                     gain_l;
  logic [GW-1:0]                     gain_r;
  logic [GW-1:0]                     prod_gain;
  logic signed [SAMPLE_BITS-1:0]     prod_sample;
  logic                              mul_en;
  logic signed [AW-1:0]              op_a;
  logic signed [BW-1:0]              op_b;
  logic signed [PW-1:0]              prod;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == stap_pkg::ST_IDLE) && !rst;
  assign out_load = (state == stap_pkg::ST_OUT) && (!out_valid || out_ch.ready);
  assign out_ch.valid = out_valid;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_gain  <= GW'(stap_pkg::GAIN_ONE);
      phase_step  <= SW'(48695);
      effect_mode <= stap_pkg::MODE_VOLUME;
    end else if (cfg_write) begin
      unique case (cfg_index)
        stap_pkg::REG_DEPTH_GAIN:  depth_gain  <= cfg_data[GW-1:0];
        stap_pkg::REG_PHASE_STEP:  phase_step  <= cfg_data[stap_pkg::STEP_W-1:0];
        stap_pkg::REG_EFFECT_MODE: effect_mode <= cfg_data[stap_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // sine table address from the current phase
  assign quad     = lfo_phase[PHASE_BITS-1 -: 2];
  assign kidx     = lfo_phase[PHASE_BITS-3 -: DL];
  assign rom_addr = quad[0] ? ((DL+1)'(SINE_TABLE_DEPTH) - {1'b0, kidx}) : {1'b0, kidx};

  stap_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .en   (in_xfer),
    .addr (rom_addr),
    .data (rom_q)
  );

  // phase accumulator, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_phase <= '0;
    end else if (in_xfer) begin
      lfo_phase <= lfo_phase + PHASE_BITS'(phase_step);
    end
  end

  // lfo value and gain terms
  assign d_sat     = (depth_gain > GW'(stap_pkg::GAIN_ONE)) ? GW'(stap_pkg::GAIN_ONE)
                                                            : depth_gain;
  assign gain_base = GW'(stap_pkg::GAIN_ONE) - d_sat;
  assign lfo_a     = quad_neg ? (GW'(stap_pkg::GAIN_HALF) - {1'b0, rom_q[15:1]})
                              : (GW'(stap_pkg::GAIN_HALF) + {1'b0, rom_q[15:1]});
  assign prod_gain   = prod[15 +: GW];
  assign prod_sample = prod[15 +: SAMPLE_BITS];

  // per-channel gain selection
  always_comb begin
    unique case (effect_mode)
      stap_pkg::MODE_TREMOLO: begin
        gain_l = gain_b;
        gain_r = gain_b;
      end
      stap_pkg::MODE_AUTOPAN: begin
        gain_l = gain_b;
        gain_r = gain_c;
      end
      default: begin
        gain_l = d_sat;
        gain_r = d_sat;
      end
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    op_a   = '0;
    op_b   = '0;
    unique case (state)
      stap_pkg::ST_MUL_A: begin
        op_a = AW'(lfo_a);
        op_b = BW'(d_sat);
      end
      stap_pkg::ST_MUL_C: begin
        op_a = AW'(GW'(stap_pkg::GAIN_ONE) - lfo_a);
        op_b = BW'(d_sat);
      end
      stap_pkg::ST_MUL_L: begin
        op_a = AW'(xl);
        op_b = BW'(gain_l);
      end
      stap_pkg::ST_MUL_R: begin
        op_a = AW'(xr);
        op_b = BW'(gain_r);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  stap_mult #(
    .AW (AW),
    .BW (BW)
  ) u_mult (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      stap_pkg::ST_IDLE:  if (in_xfer) state_next = stap_pkg::ST_MUL_A;
      stap_pkg::ST_MUL_A: state_next = stap_pkg::ST_MUL_C;
      stap_pkg::ST_MUL_C: state_next = stap_pkg::ST_MUL_L;
      stap_pkg::ST_MUL_L: state_next = stap_pkg::ST_MUL_R;
      stap_pkg::ST_MUL_R: state_next = stap_pkg::ST_OUT;
      stap_pkg::ST_OUT:   if (out_load) state_next = stap_pkg::ST_IDLE;
      default:            state_next = stap_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stap_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture samples and quadrant sign on the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      xl       <= in_ch.left_in;
      xr       <= in_ch.right_in;
      quad_neg <= quad[1];
    end
  end

  // gain and left result registers
  always_ff @(posedge clk) begin
    if (state == stap_pkg::ST_MUL_C) begin
      gain_b <= gain_base + prod_gain;
    end
    if (state == stap_pkg::ST_MUL_L) begin
      gain_c <= gain_base + prod_gain;
    end
    if (state == stap_pkg::ST_MUL_R) begin
      res_l <= prod_sample;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.left_out  <= res_l;
      out_ch.right_out <= prod_sample;
    end
  end

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == stap_pkg::ST_MUL_A)
    else $error("accepted pair did not start the multiply sequence");

  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> lfo_phase == $past(lfo_phase) + PHASE_BITS'($past(phase_step)))
    else $error("phase did not advance by one step on transfer");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !in_xfer |=> $stable(lfo_phase))
    else $error("phase moved without an input transfer");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == stap_pkg::ST_OUT)
    else $error("output valid raised outside the output state");

  a_gain_limit: assert property (@(posedge clk) disable iff (rst)
    state == stap_pkg::ST_MUL_L |-> gain_b <= GW'(stap_pkg::GAIN_ONE))
    else $error("lfo gain above unity");
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// testbench for the stereo tremolo / auto-pan unit: stereo pairs checked against a bench gain model
module tb_top;

  localparam int                     GW = stap_pkg::GAIN_W;
  localparam int                     SW = stap_pkg::STEP_W;
  localparam int                     MW = stap_pkg::MODE_W;
  localparam int                     CW = stap_pkg::CFG_W;
  localparam int                     IW = stap_pkg::CIDX_W;
  localparam int unsigned            GAIN_ONE  = stap_pkg::GAIN_ONE;
  localparam int unsigned            GAIN_HALF = stap_pkg::GAIN_HALF;

  localparam int unsigned            LUT_DEPTH = 256;
  localparam logic [MW-1:0]          MODE_SPARE = 2'd3;
  localparam logic [CW-1:0]          DEPTH_MAX  = 22'h00FFFF;
  localparam logic [CW-1:0]          STEP_MAX   = 22'h3FFFFF;
  localparam int unsigned            SWEEP_PAIRS = 270;
  localparam int unsigned            PHASE_PAIRS = 25;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } stereo_pair_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [IW-1:0]      cfg_index;
  logic [CW-1:0]      cfg_data;

  stap_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  stap_out_if #(.SAMPLE_BITS(16)) out_ch ();

  stereo_tremolo_autopan_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bench copy of the registers and the lfo accumulator
  logic [GW-1:0]      depth_reg;
  logic [SW-1:0]      step_reg;
  logic [MW-1:0]      mode_reg;
  logic [31:0]        lfo_acc;
  logic [15:0]        sine_lut [0:LUT_DEPTH];

  stereo_pair_t pending_pairs [$];
  int errors    = 0;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // quarter-wave sine in q15, odd series evaluated from the inside out in q30
  function automatic logic [15:0] quarter_sine(input int unsigned k);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned poly;
    longint unsigned mag;
    longint unsigned divs [5];
    divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    ang  = (64'(k) * 64'd1686629713) / 64'(LUT_DEPTH);
    ang2 = (ang * ang) >> 30;
    poly = 64'd1 << 30;
    foreach (divs[i]) begin
      poly = (64'd1 << 30) - ((ang2 * poly) >> 30) / divs[i];
    end
    mag = (((ang * poly) >> 30) + (64'd1 << 14)) >> 15;
    if (mag > 64'(GAIN_ONE)) begin
      mag = 64'(GAIN_ONE);
    end
    return mag[15:0];
  endfunction

  // lfo value in [0,1] q15 from the top ten phase bits
  function automatic int unsigned lfo_level(input logic [31:0] phase);
    logic [9:0]  idx;
    int unsigned mag;
    idx = phase[31:22];
    mag = idx[8] ? sine_lut[LUT_DEPTH - idx[7:0]] : sine_lut[idx[7:0]];
    return idx[9] ? GAIN_HALF - (mag >> 1) : GAIN_HALF + (mag >> 1);
  endfunction

  // q15 gain, truncated toward minus infinity
  function automatic logic signed [15:0] apply_gain(input logic signed [15:0] x,
                                                    input int unsigned gain);
    longint prod;
    prod = longint'(x) * longint'(gain);
    return 16'(prod >>> 15);
  endfunction

  function automatic stereo_pair_t modulated_pair(input logic signed [15:0] l,
                                                  input logic signed [15:0] r);
    int unsigned  d;
    int unsigned  a;
    int unsigned  b;
    int unsigned  c;
    int unsigned  gl;
    int unsigned  gr;
    stereo_pair_t p;
    d = (depth_reg > GAIN_ONE) ? GAIN_ONE : depth_reg;
    a = lfo_level(lfo_acc);
    b = (GAIN_ONE - d) + ((a * d) >> 15);
    c = (GAIN_ONE - d) + (((GAIN_ONE - a) * d) >> 15);
    case (mode_reg)
      stap_pkg::MODE_TREMOLO: begin
        gl = b;
        gr = b;
      end
      stap_pkg::MODE_AUTOPAN: begin
        gl = b;
        gr = c;
      end
      // volume, and the spare code acts as volume
      default: begin
        gl = d;
        gr = d;
      end
    endcase
    p.left  = apply_gain(l, gl);
    p.right = apply_gain(r, gr);
    return p;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_pair(input logic signed [15:0] l, input logic signed [15:0] r);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_pairs.push_back(modulated_pair(l, r));
    lfo_acc = lfo_acc + 32'(step_reg);
    @(negedge clk);
  endtask

  // stop sending and wait for every pending pair to come out
  task automatic drain_pairs();
    in_ch.valid <= 1'b0;
    while (pending_pairs.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      stap_pkg::REG_DEPTH_GAIN:  depth_reg = val[GW-1:0];
      stap_pkg::REG_PHASE_STEP:  step_reg  = val[SW-1:0];
      stap_pkg::REG_EFFECT_MODE: mode_reg  = val[MW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CW-1:0] depth, input logic [CW-1:0] step,
                           input logic [MW-1:0] mode);
    write_reg(stap_pkg::REG_DEPTH_GAIN, depth);
    write_reg(stap_pkg::REG_PHASE_STEP, step);
    write_reg(stap_pkg::REG_EFFECT_MODE, CW'(mode));
  endtask

  task automatic random_config();
    logic [CW-1:0] depth;
    logic [CW-1:0] step;
    case ($urandom_range(4))
      0:       depth = '0;
      1:       depth = CW'(GAIN_ONE);
      2:       depth = DEPTH_MAX;
      3:       depth = CW'($urandom_range(65535));
      default: depth = CW'($urandom_range(GAIN_ONE));
    endcase
    step = $urandom_range(1) ? CW'($urandom_range(STEP_MAX))
                             : STEP_MAX - CW'($urandom_range(4096));
    configure(depth, step, MW'($urandom_range(3)));
  endtask

  // default registers straight out of reset
  task automatic test_reset_defaults();
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh0000, -16'sd1);
    send_pair(16'sd1, 16'sh0000);
    drain_pairs();
  endtask

  // volume mode over the depth range, saturation above one and the spare mode
  task automatic test_volume_depth();
    configure('0, '0, stap_pkg::MODE_VOLUME);
    send_pair(16'sh7FFF, 16'sh8000);
    drain_pairs();
    write_reg(stap_pkg::REG_DEPTH_GAIN, CW'(GAIN_HALF));
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(-16'sd1, 16'sd1);
    drain_pairs();
    write_reg(stap_pkg::REG_DEPTH_GAIN, DEPTH_MAX);
    send_pair(16'sh8000, 16'sh7FFF);
    drain_pairs();
    write_reg(stap_pkg::REG_DEPTH_GAIN, CW'(GAIN_ONE - 1));
    send_pair(16'sh7FFF, 16'sh8000);
    drain_pairs();
    configure(22'd12345, '0, MODE_SPARE);
    send_pair(16'sd20000, -16'sd20000);
    drain_pairs();
  endtask

  // tremolo and auto-pan with a frozen and a fast lfo
  task automatic test_lfo_gains();
    configure(CW'(GAIN_ONE), '0, stap_pkg::MODE_TREMOLO);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    drain_pairs();
    configure(CW'(GAIN_HALF), '0, stap_pkg::MODE_AUTOPAN);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh8000);
    drain_pairs();
    configure(CW'(GAIN_ONE), STEP_MAX, stap_pkg::MODE_AUTOPAN);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(-16'sd1, -16'sd1);
    send_pair(16'sd1, 16'sd1);
    drain_pairs();
    configure('0, STEP_MAX, stap_pkg::MODE_TREMOLO);
    send_pair(16'sh8000, 16'sh7FFF);
    drain_pairs();
  endtask

  // long run at the largest step so the lfo crosses from the first into the second quarter
  task automatic test_lfo_sweep();
    idle_pct  = 0;
    stall_pct = 0;
    configure(CW'($urandom_range(GAIN_ONE)), STEP_MAX, stap_pkg::MODE_AUTOPAN);
    repeat (SWEEP_PAIRS) send_pair(rand_sample(), rand_sample());
    drain_pairs();
  endtask

  task automatic test_random_traffic(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    random_config();
    repeat (PHASE_PAIRS) send_pair(rand_sample(), rand_sample());
    drain_pairs();
  endtask

  // long output hold-off so the unit fills up, then a full drain and a restart
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    random_config();
    @(posedge clk);
    hold_left = 60;
    @(negedge clk);
    repeat (20) send_pair(rand_sample(), rand_sample());
    drain_pairs();
    repeat (20) send_pair(rand_sample(), rand_sample());
    drain_pairs();
  endtask

  // output ready: random stalls, or a held-off stretch when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare each output transfer with the oldest predicted pair
  always @(posedge clk) begin
    stereo_pair_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected output pair, expected none, actual %0d %0d",
                 $time, out_ch.left_out, out_ch.right_out);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_ch.left_out !== want.left) begin
          $display("%0t: left_out mismatch, expected %0d, actual %0d",
                   $time, want.left, out_ch.left_out);
          errors++;
        end
        if (out_ch.right_out !== want.right) begin
          $display("%0t: right_out mismatch, expected %0d, actual %0d",
                   $time, want.right, out_ch.right_out);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;
    out_ch.ready   = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = stap_pkg::REG_DEPTH_GAIN;
    cfg_data       = '0;
    rst            = 1'b1;
    depth_reg      = GW'(GAIN_ONE);
    step_reg       = 22'd48695;
    mode_reg       = stap_pkg::MODE_VOLUME;
    lfo_acc        = '0;
    for (int k = 0; k <= LUT_DEPTH; k++) begin
      sine_lut[k] = quarter_sine(k);
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_volume_depth();
    test_lfo_gains();
    test_lfo_sweep();
    test_random_traffic(0, 0);
    test_random_traffic(79, 0);
    test_random_traffic(0, 79);
    test_random_traffic(36, 36);
    test_backpressure();

    drain_pairs();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
